>>> rtl/core/ordered_list_store_assert.svh
// ----------------------------------------------------------------------------
// ordered list store assertion macros
// concurrent assertion wrappers, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OLS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/ols_pkg.sv
// ----------------------------------------------------------------------------
// ordered list store package
// command codes, status codes, field widths and control structs
// ----------------------------------------------------------------------------
package ols_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 3;
    localparam int FOUND_W = 6;
    localparam int TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [ST_W-1:0] ST_BOUNDS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic latch;
        logic start;
        logic rd;
        logic rd_here;
        logic wr_move;
        logic wr_val;
        logic step;
        logic inc_count;
        logic dec_count;
        logic take;
        logic hit;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic work;
        logic is_ins;
        logic is_del;
        logic more;
        logic match;
        logic out_busy;
    } stat_t;

endpackage

>>> rtl/core/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered list store
// ordered sequence of signed values with insert, delete and search commands
// ----------------------------------------------------------------------------
// one command at a time via the entry memory (one write port, registered read)
// error or op 7: check, then result; insert: shift entries from its position up,
// then write the value; delete: read and take the entry, shift the rest down;
// search: compare from the head to a hit or the end; results wait on m_tready;
// s_tready rises with m_tvalid; reset empties the store at once, not entry memory
module ordered_list_store #(
    parameter int DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op[2:0], position[8:3], value[40:9], zero fill
    input  logic [ols_pkg::TDATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[2:0], removed_value[34:3], found_position[40:35], zero fill
    output logic [ols_pkg::TDATA_W-1:0]  m_tdata
);
    import ols_pkg::*;

    `include "ordered_list_store_assert.svh"

    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [CW-1:0] entry_count;

    ols_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ols_dp #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .entry_count (entry_count),
        .cmd         (cmd),
        .stat        (stat)
    );

    `OLS_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, entry_count <= CW'(DEPTH))
    `OLS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `OLS_ASSERT_NEXT(a_count_idle_stable, aclk, aresetn, s_tready, $stable(entry_count))

endmodule

>>> rtl/core/ols_ctrl.sv
// ----------------------------------------------------------------------------
// ordered list store controller
// sequences check, shift, search and result hand-off per command
// ----------------------------------------------------------------------------
module ols_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output ols_pkg::cmd_t cmd,
    input  ols_pkg::stat_t stat
);
    import ols_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_CHECK     = 9'b000000010,
        S_DEL_READ  = 9'b000000100,
        S_DEL_TAKE  = 9'b000001000,
        S_MOVE_TEST = 9'b000010000,
        S_MOVE_WR   = 9'b000100000,
        S_SR_TEST   = 9'b001000000,
        S_SR_CMP    = 9'b010000000,
        S_FINISH    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.start = 1'b1;
                if (!stat.work) begin
                    state_next = S_FINISH;
                end else if (stat.is_ins) begin
                    state_next = S_MOVE_TEST;
                end else if (stat.is_del) begin
                    state_next = S_DEL_READ;
                end else begin
                    state_next = S_SR_TEST;
                end
            end
            S_DEL_READ: begin
                cmd.rd      = 1'b1;
                cmd.rd_here = 1'b1;
                state_next  = S_DEL_TAKE;
            end
            S_DEL_TAKE: begin
                cmd.take   = 1'b1;
                state_next = S_MOVE_TEST;
            end
            S_MOVE_TEST: begin
                if (stat.more) begin
                    cmd.rd     = 1'b1;
                    state_next = S_MOVE_WR;
                end else begin
                    cmd.wr_val    = stat.is_ins;
                    cmd.inc_count = stat.is_ins;
                    cmd.dec_count = stat.is_del;
                    state_next    = S_FINISH;
                end
            end
            S_MOVE_WR: begin
                cmd.wr_move = 1'b1;
                cmd.step    = 1'b1;
                state_next  = S_MOVE_TEST;
            end
            S_SR_TEST: begin
                if (stat.more) begin
                    cmd.rd     = 1'b1;
                    state_next = S_SR_CMP;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SR_CMP: begin
                if (stat.match) begin
                    cmd.hit    = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_SR_TEST;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/ols_dp.sv
// ----------------------------------------------------------------------------
// ordered list store datapath
// entry memory, count, command checks, shift index and result registers
// ----------------------------------------------------------------------------
module ols_dp #(
    parameter int DEPTH = 32,
    parameter int CW    = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ols_pkg::TDATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ols_pkg::TDATA_W-1:0]  m_tdata,
    output logic [CW-1:0]                entry_count,
    input  ols_pkg::cmd_t                cmd,
    output ols_pkg::stat_t               stat
);
    import ols_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = (CW > POS_W) ? CW + 1 : POS_W + 1;

    logic [VAL_W-1:0]   mem [DEPTH];
    logic [VAL_W-1:0]   rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic               wr_en;

    logic [OP_W-1:0]    op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      at_reg;
    logic [CW-1:0]      idx_reg;
    logic [ST_W-1:0]    res_status_reg;
    logic [VAL_W-1:0]   res_removed_reg;
    logic [FOUND_W-1:0] res_found_reg;

    logic               out_valid_reg;
    logic [ST_W-1:0]    out_status_reg;
    logic [VAL_W-1:0]   out_removed_reg;
    logic [FOUND_W-1:0] out_found_reg;

    logic               is_ins, is_del, is_srch;
    logic [ST_W-1:0]    chk_status;
    logic [CW-1:0]      at_calc;
    logic [LW-1:0]      count_l, pos_l;

    assign is_ins  = (op_reg == OP_INS_HEAD) || (op_reg == OP_INS_TAIL) ||
                     (op_reg == OP_INS_AT);
    assign is_del  = (op_reg == OP_DEL_HEAD) || (op_reg == OP_DEL_TAIL) ||
                     (op_reg == OP_DEL_AT);
    assign is_srch = (op_reg == OP_SEARCH);
    assign count_l = LW'(count_reg);
    assign pos_l   = LW'(pos_reg);

    always_comb begin
        chk_status = ST_OK;
        if (is_ins) begin
            if ((op_reg == OP_INS_AT) && (pos_reg == '0)) begin
                chk_status = ST_INVALID;
            end else if ((op_reg == OP_INS_AT) && (pos_l > count_l + LW'(1))) begin
                chk_status = ST_BOUNDS;
            end else if (count_reg == CW'(DEPTH)) begin
                chk_status = ST_FULL;
            end
        end else if (is_del) begin
            if (count_reg == '0) begin
                chk_status = ST_EMPTY;
            end else if ((op_reg == OP_DEL_AT) && (pos_reg == '0)) begin
                chk_status = ST_INVALID;
            end else if ((op_reg == OP_DEL_AT) && (pos_l > count_l)) begin
                chk_status = ST_BOUNDS;
            end
        end else if (is_srch) begin
            chk_status = (count_reg == '0) ? ST_EMPTY : ST_NOTFOUND;
        end
    end

    always_comb begin
        case (op_reg)
            OP_INS_TAIL:          at_calc = count_reg;
            OP_DEL_TAIL:          at_calc = count_reg - CW'(1);
            OP_INS_AT, OP_DEL_AT: at_calc = CW'(pos_l - LW'(1));
            default:              at_calc = '0;
        endcase
    end

    always_comb begin
        stat.is_ins   = is_ins;
        stat.is_del   = is_del;
        stat.work     = ((is_ins || is_del) && (chk_status == ST_OK)) ||
                        (is_srch && (chk_status == ST_NOTFOUND));
        stat.match    = (rd_data_reg == val_reg);
        stat.out_busy = out_valid_reg && !m_tready;
        if (is_ins) begin
            stat.more = (idx_reg != CW'(at_reg));
        end else if (is_del) begin
            stat.more = (idx_reg + CW'(1)) < count_reg;
        end else begin
            stat.more = idx_reg < count_reg;
        end
    end

    // read and write addresses of the shift sweep, the delete read, the search and the insert write
    always_comb begin
        if (cmd.rd_here || is_srch) begin
            rd_addr = AW'(idx_reg);
        end else if (is_ins) begin
            rd_addr = AW'(idx_reg - CW'(1));
        end else begin
            rd_addr = AW'(idx_reg + CW'(1));
        end
        wr_en   = cmd.wr_move || cmd.wr_val;
        wr_addr = cmd.wr_val ? at_reg : AW'(idx_reg);
        wr_data = cmd.wr_val ? val_reg : rd_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.inc_count) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.dec_count) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_tdata[OP_W-1:0];
            pos_reg <= s_tdata[OP_W+POS_W-1:OP_W];
            val_reg <= s_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];
        end
        if (cmd.start) begin
            at_reg          <= AW'(at_calc);
            idx_reg         <= is_ins ? count_reg : (is_del ? at_calc : '0);
            res_status_reg  <= chk_status;
            res_removed_reg <= '0;
            res_found_reg   <= '0;
        end else if (cmd.step) begin
            idx_reg <= is_ins ? idx_reg - CW'(1) : idx_reg + CW'(1);
        end
        if (cmd.take) begin
            res_removed_reg <= rd_data_reg;
        end
        if (cmd.hit) begin
            res_status_reg <= ST_OK;
            res_found_reg  <= FOUND_W'(LW'(idx_reg) + LW'(1));
        end
        if (cmd.load_result) begin
            out_status_reg  <= res_status_reg;
            out_removed_reg <= res_removed_reg;
            out_found_reg   <= res_found_reg;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {(TDATA_W - ST_W - VAL_W - FOUND_W)'(0),
                          out_found_reg, out_removed_reg, out_status_reg};
    assign entry_count = count_reg;

endmodule
